// ----- hw/rtl/skt_pkg.sv -----
`default_nettype none

package skt_pkg;

    localparam int unsigned POS_BITS   = 6;
    localparam int unsigned COUNT_BITS = 7;
    localparam int unsigned STAT_BITS  = 2;
    localparam int unsigned KEY_WIDTH  = 32;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [STAT_BITS-1:0] ST_DONE      = 2'd0;
    localparam logic [STAT_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STAT_BITS-1:0] ST_FULL      = 2'd2;

    typedef struct packed {
        logic                 operation;
        logic [KEY_WIDTH-1:0] key;
    } t_req;

    typedef struct packed {
        logic [POS_BITS-1:0]   position;
        logic [STAT_BITS-1:0]  status;
        logic [COUNT_BITS-1:0] entry_count;
    } t_rsp;

    typedef enum logic [1:0] {
        POS_ZERO,
        POS_MID,
        POS_SLOT
    } t_pos_sel;

    typedef struct packed {
        logic                 start;
        logic                 rd_mid;
        logic                 step;
        logic                 shift;
        logic                 put;
        logic                 emit;
        t_pos_sel             pos_sel;
        logic [STAT_BITS-1:0] status;
    } t_cmd;

    typedef struct packed {
        logic lookup;
        logic full;
        logic range_open;
        logic hit;
        logic shift_more;
        logic out_free;
    } t_sts;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_key_table_search_insert.sv -----
// Sorted key table: keeps up to TABLE_DEPTH keys in ascending order in a single-port-write,
// registered-read memory. A lookup (operation 1) binary-searches the held keys and returns the
// index of the first match it probes, or status 1 if none; an insert (operation 0) finds the
// first key not below the new one, moves the later keys up one place and writes the key there,
// returning its index, or status 2 with nothing changed when the table is full. Requests are
// handled one at a time. Each binary-search step passes through the check, probe and compare
// states (range test, address and registered read, compare); an insert then adds the key moves,
// paced by the one read and one write the memory offers per cycle, and the key write. A finished
// response sits in an output register, so the next request can be taken while it waits for the
// receiver; a new response is loaded only once the previous one has been taken. Only the low
// KEY_BITS bits of the key take part; position and entry_count carry the low bits of the index
// and count.
`default_nettype none

module sorted_key_table_search_insert
    import skt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned KEY_BITS    = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_req i_req,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    t_cmd cmd;
    t_sts sts;

    skt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    skt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .KEY_BITS    (KEY_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/skt_dp.sv -----
`default_nettype none

module skt_dp
    import skt_pkg::*;
#(
    parameter int unsigned TABLE_DEPTH = 64,
    parameter int unsigned KEY_BITS    = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_req i_req,
    input  wire t_cmd i_cmd,
    output t_sts      o_sts,
    output logic      o_rsp_valid,
    input  wire logic i_rsp_ready,
    output t_rsp      o_rsp
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

    logic [KEY_BITS-1:0] r_mem [TABLE_DEPTH];
    logic [KEY_BITS-1:0] r_rdata;
    logic [KEY_BITS-1:0] r_key;
    logic                r_op;
    logic [CW-1:0]       r_count;
    logic [CW-1:0]       r_lo;
    logic [CW-1:0]       r_hi;
    logic [CW-1:0]       r_sh;
    logic [AW-1:0]       r_mid;
    logic                r_wb_vld;
    logic [AW-1:0]       r_wb_addr;
    logic                r_out_vld;
    t_rsp                r_out;

    logic [CW:0]   mid_sum;
    logic [AW-1:0] mid_calc;
    logic [CW-1:0] sh_dec;
    logic [AW-1:0] raddr;
    logic          go_left;
    logic [POS_BITS-1:0] pos_val;

    assign mid_sum  = {1'b0, r_lo} + {1'b0, r_hi} - (CW + 1)'(1);
    assign mid_calc = mid_sum[AW:1];
    assign sh_dec   = r_sh - CW'(1);
    assign raddr    = i_cmd.shift ? sh_dec[AW-1:0] : mid_calc;
    assign go_left  = (r_op == OP_LOOKUP) ? (r_key < r_rdata) : (r_key <= r_rdata);

    always_comb begin
        case (i_cmd.pos_sel)
            POS_MID:  pos_val = POS_BITS'(r_mid);
            POS_SLOT: pos_val = POS_BITS'(r_lo);
            default:  pos_val = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[raddr];
        if (i_cmd.put) begin
            r_mem[r_lo[AW-1:0]] <= r_key;
        end else if (r_wb_vld) begin
            r_mem[r_wb_addr] <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_key <= KEY_BITS'(i_req.key);
            r_op  <= i_req.operation;
            r_lo  <= '0;
            r_hi  <= r_count;
            r_sh  <= r_count;
        end
        if (i_cmd.rd_mid) begin
            r_mid <= mid_calc;
        end
        if (i_cmd.step) begin
            if (go_left) begin
                r_hi <= CW'(r_mid);
            end else begin
                r_lo <= CW'(r_mid) + CW'(1);
            end
        end
        if (i_cmd.shift) begin
            r_sh      <= sh_dec;
            r_wb_addr <= r_sh[AW-1:0];
        end
        if (i_cmd.emit) begin
            r_out.position    <= pos_val;
            r_out.status      <= i_cmd.status;
            r_out.entry_count <= COUNT_BITS'(r_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_wb_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_wb_vld <= i_cmd.shift;
            if (i_cmd.put) begin
                r_count <= r_count + CW'(1);
            end
            if (i_cmd.emit) begin
                r_out_vld <= 1'b1;
            end else if (i_rsp_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_sts.lookup     = (r_op == OP_LOOKUP);
    assign o_sts.full       = (r_count == CW'(TABLE_DEPTH));
    assign o_sts.range_open = (r_lo < r_hi);
    assign o_sts.hit        = (r_key == r_rdata);
    assign o_sts.shift_more = (r_sh > r_lo);
    assign o_sts.out_free   = !r_out_vld || i_rsp_ready;

    assign o_rsp_valid = r_out_vld;
    assign o_rsp       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_one_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_cmd.put && r_wb_vld))
        else $error("key write collides with shift write-back");

    a_put_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |-> !o_sts.full)
        else $error("insert into full table");

    a_put_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.put |=> r_count == $past(r_count) + CW'(1))
        else $error("entry count not advanced by insert");

endmodule

`default_nettype wire

// ----- hw/rtl/skt_ctrl.sv -----
`default_nettype none

module skt_ctrl
    import skt_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_req_valid,
    output logic      o_req_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_PROBE,
        S_CMP,
        S_SHIFT,
        S_PUT,
        S_EMIT
    } t_state;

    t_state               r_state;
    t_state               n_state;
    t_pos_sel             r_pos_sel;
    t_pos_sel             n_pos_sel;
    logic [STAT_BITS-1:0] r_status;
    logic [STAT_BITS-1:0] n_status;

    always_comb begin
        n_state   = r_state;
        n_pos_sel = r_pos_sel;
        n_status  = r_status;
        o_cmd     = '0;
        o_cmd.pos_sel = r_pos_sel;
        o_cmd.status  = r_status;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.lookup) begin
                    if (i_sts.range_open) begin
                        n_state = S_PROBE;
                    end else begin
                        n_pos_sel = POS_ZERO;
                        n_status  = ST_NOT_FOUND;
                        n_state   = S_EMIT;
                    end
                end else if (i_sts.full) begin
                    n_pos_sel = POS_ZERO;
                    n_status  = ST_FULL;
                    n_state   = S_EMIT;
                end else if (i_sts.range_open) begin
                    n_state = S_PROBE;
                end else begin
                    n_state = S_SHIFT;
                end
            end
            S_PROBE: begin
                o_cmd.rd_mid = 1'b1;
                n_state      = S_CMP;
            end
            S_CMP: begin
                if (i_sts.lookup && i_sts.hit) begin
                    n_pos_sel = POS_MID;
                    n_status  = ST_DONE;
                    n_state   = S_EMIT;
                end else begin
                    o_cmd.step = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_SHIFT: begin
                if (i_sts.shift_more) begin
                    o_cmd.shift = 1'b1;
                end else begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                o_cmd.put = 1'b1;
                n_pos_sel = POS_SLOT;
                n_status  = ST_DONE;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_pos_sel <= POS_ZERO;
            r_status  <= ST_DONE;
        end else begin
            r_state   <= n_state;
            r_pos_sel <= n_pos_sel;
            r_status  <= n_status;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb
    import skt_pkg::*;
();

    localparam int DEPTH       = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int DIRECTED_END_WAIT = 200;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_req_valid = 1'b0;
    logic o_req_ready;
    t_req i_req       = '0;
    logic o_rsp_valid;
    logic i_rsp_ready = 1'b0;
    t_rsp o_rsp;

    sorted_key_table_search_insert i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_req                 pending_requests[$];
    t_rsp                 answers_due[$];
    logic [KEY_WIDTH-1:0] issued_keys[$];

    logic [KEY_WIDTH-1:0] shadow_keys [DEPTH];
    int                   shadow_fill = 0;

    int unsigned send_idle_pct = 9;
    int unsigned take_idle_pct = 73;
    int unsigned quiet_cycles  = 0;
    int unsigned errors        = 0;
    int unsigned answers_seen  = 0;
    int unsigned lookups       = 0;
    int unsigned lookup_hits   = 0;
    int unsigned inserts_done  = 0;
    int unsigned inserts_dropped = 0;
    bit          req_taken;

    function automatic t_rsp apply_to_table(t_req rq);
        t_rsp ans;
        int   lo;
        int   hi;
        int   mid;
        int   slot;
        bit   found;
        ans   = '0;
        found = 1'b0;
        if (rq.operation == OP_LOOKUP) begin
            lookups++;
            ans.status = ST_NOT_FOUND;
            lo = 0;
            hi = shadow_fill - 1;
            while (lo <= hi && !found) begin
                mid = (lo + hi) / 2;
                if (rq.key == shadow_keys[mid]) begin
                    found        = 1'b1;
                    ans.position = mid[POS_BITS-1:0];
                    ans.status   = ST_DONE;
                end else if (rq.key < shadow_keys[mid]) begin
                    hi = mid - 1;
                end else begin
                    lo = mid + 1;
                end
            end
            if (found) lookup_hits++;
        end else if (shadow_fill >= DEPTH) begin
            inserts_dropped++;
            ans.status = ST_FULL;
        end else begin
            inserts_done++;
            slot = shadow_fill;
            for (int i = 0; i < shadow_fill; i++) begin
                if (!found && shadow_keys[i] >= rq.key) begin
                    slot  = i;
                    found = 1'b1;
                end
            end
            for (int i = shadow_fill; i > slot; i--) shadow_keys[i] = shadow_keys[i-1];
            shadow_keys[slot] = rq.key;
            shadow_fill++;
            ans.position = slot[POS_BITS-1:0];
            ans.status   = ST_DONE;
        end
        ans.entry_count = shadow_fill[COUNT_BITS-1:0];
        return ans;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
        end else begin
            req_taken = i_req_valid && o_req_ready;
            if (req_taken) begin
                answers_due.insert(answers_due.size(), apply_to_table(i_req));
            end
            if ((!i_req_valid || req_taken) && pending_requests.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                i_req_valid <= 1'b1;
                i_req       <= pending_requests.pop_front();
            end else if (req_taken) begin
                i_req_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_ready <= 1'b0;
        end else begin
            if (o_rsp_valid && i_rsp_ready) begin
                answers_seen++;
                if (answers_due.size() == 0) begin
                    errors++;
                    $display("%0t: answer with none due: got %p", $time, o_rsp);
                end else begin
                    t_rsp want;
                    want = answers_due.pop_front();
                    if (o_rsp.position !== want.position) begin
                        errors++;
                        $display("%0t: position expected %0d actual %0d",
                                 $time, want.position, o_rsp.position);
                    end
                    if (o_rsp.status !== want.status) begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, o_rsp.status);
                    end
                    if (o_rsp.entry_count !== want.entry_count) begin
                        errors++;
                        $display("%0t: entry_count expected %0d actual %0d",
                                 $time, want.entry_count, o_rsp.entry_count);
                    end
                end
            end
            i_rsp_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic queue_request(logic op, logic [KEY_WIDTH-1:0] key);
        t_req rq;
        rq.operation = op;
        rq.key       = key;
        pending_requests.insert(pending_requests.size(), rq);
        if (op == OP_INSERT) issued_keys.insert(issued_keys.size(), key);
    endtask

    function automatic logic [KEY_WIDTH-1:0] pick_key(logic op);
        int unsigned          roll;
        logic [KEY_WIDTH-1:0] near;
        roll = $urandom_range(99);
        near = (issued_keys.size() > 0) ?
               issued_keys[$urandom_range(issued_keys.size() - 1)] : $urandom;
        if (op == OP_LOOKUP) begin
            if (roll < 50) return near;
            if (roll < 70) return $urandom_range(1) ? near + 1 : near - 1;
            if (roll < 75) return $urandom_range(1) ? '1 : '0;
        end else begin
            if (roll < 20) return near;
            if (roll < 25) return $urandom_range(1) ? '1 : '0;
            if (roll < 35) return $urandom_range(1) ? near + 1 : near - 1;
        end
        return $urandom;
    endfunction

    task automatic queue_random(int count);
        logic op;
        repeat (count) begin
            op = ($urandom_range(9) == 0) ? OP_INSERT : OP_LOOKUP;
            queue_request(op, pick_key(op));
        end
    endtask

    task automatic wait_for_drain();
        while (pending_requests.size() > 0 || i_req_valid || answers_due.size() > 0)
            @(posedge i_clk);
    endtask

    initial begin
        queue_request(OP_LOOKUP, 32'h0000_0000);
        queue_request(OP_LOOKUP, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 32'h8000_0000);
        queue_request(OP_INSERT, 32'h0000_0000);
        queue_request(OP_INSERT, 32'hFFFF_FFFF);
        queue_request(OP_INSERT, 32'h8000_0000);
        queue_request(OP_INSERT, 32'h8000_0000);
        queue_request(OP_INSERT, 32'h7FFF_FFFF);
        queue_request(OP_INSERT, 32'h8000_0001);
        queue_request(OP_LOOKUP, 32'h0000_0000);
        queue_request(OP_LOOKUP, 32'hFFFF_FFFF);
        queue_request(OP_LOOKUP, 32'h8000_0000);
        queue_request(OP_LOOKUP, 32'h7FFF_FFFF);
        queue_request(OP_LOOKUP, 32'h8000_0001);
        queue_request(OP_LOOKUP, 32'h0000_0001);
        queue_request(OP_LOOKUP, 32'hFFFF_FFFE);
        queue_request(OP_INSERT, 32'h0000_0000);
        queue_request(OP_LOOKUP, 32'h0000_0000);
        queue_request(OP_INSERT, 32'h5555_5555);
        queue_request(OP_INSERT, 32'hAAAA_AAAA);
        queue_request(OP_LOOKUP, 32'h5555_5555);
        queue_request(OP_LOOKUP, 32'hAAAA_AAAA);
        queue_random(460);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // hold until every answer is back
        wait_for_drain();
        send_idle_pct = 73;
        take_idle_pct = 9;
        queue_random(485);
        wait_for_drain();

        send_idle_pct = 0;
        take_idle_pct = 0;
        queue_random(485);
        wait_for_drain();

        repeat (DIRECTED_END_WAIT) @(posedge i_clk);
        $display("covered %0d lookups (%0d found) and %0d inserts placed, %0d dropped when full",
                 lookups, lookup_hits, inserts_done, inserts_dropped);
        $display("checked %0d answers under three sender/receiver stall mixes", answers_seen);
        if (errors == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/skt_pkg.sv
hw/rtl/skt_dp.sv
hw/rtl/skt_ctrl.sv
hw/rtl/sorted_key_table_search_insert.sv
test/tb.sv
